// ===== sv/plrb_pkg.sv =====
// plrb_pkg: shared types, constants and helpers of the priority lossy ring buffer
// used by the channel interfaces, the slot ram and the top level
`default_nettype none

package plrb_pkg;

	// ring geometry
	localparam int SLOTS       = 1024;
	localparam int PTR_W       = $clog2(SLOTS);
	localparam int COUNT_LIMIT = 100;
	localparam int CNT_W       = 7;
	localparam int LEVEL_W     = 3;
	localparam int DATA_W      = 64;

	// operation codes of an input item
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_PUSH_OK   = 2'd0,
		ST_PUSH_DROP = 2'd1,
		ST_POP_OK    = 2'd2,
		ST_POP_EMPTY = 2'd3
	} status_t;

	typedef logic [PTR_W-1:0] ptr_t;

	// one ring slot as kept in the slot ram
	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [LEVEL_W-1:0] level;
		logic [DATA_W-1:0]  payload;
	} entry_t;

	// advance a ring pointer with wrap
	function automatic ptr_t ptr_inc(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	// raise a write count, saturating at the limit
	function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c >= CNT_W'(COUNT_LIMIT)) begin
			r = c;
		end else begin
			r = c + 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/plrb_req_if.sv =====
// plrb_req_if: request channel (push or pop items) with valid/ready handshake
// depends on plrb_pkg
`default_nettype none

interface plrb_req_if import plrb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [LEVEL_W-1:0] level_in;
	logic [DATA_W-1:0]  payload_in;

	modport source (output valid, kind, level_in, payload_in, input ready);
	modport sink   (input valid, kind, level_in, payload_in, output ready);
endinterface

`default_nettype wire

// ===== sv/plrb_rsp_if.sv =====
// plrb_rsp_if: result channel (one result per request) with valid/ready handshake
// depends on plrb_pkg
`default_nettype none

interface plrb_rsp_if import plrb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [DATA_W-1:0]  payload_out;
	logic [LEVEL_W-1:0] level_out;
	logic               skipped;

	modport source (output valid, status, payload_out, level_out, skipped, input ready);
	modport sink   (input valid, status, payload_out, level_out, skipped, output ready);
endinterface

`default_nettype wire

// ===== sv/plrb_slot_ram.sv =====
// plrb_slot_ram: slot storage, one write port and one registered read port
// depends on plrb_pkg (entry_t, ptr_t, SLOTS)
`default_nettype none

module plrb_slot_ram import plrb_pkg::*; (
	input  wire logic   clk,
	input  wire logic   we,
	input  wire ptr_t   waddr,
	input  wire entry_t wdata,
	input  wire logic   re,
	input  wire ptr_t   raddr,
	output entry_t      rdata
);

	entry_t mem [SLOTS];
	entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/priority_lossy_ring_buffer.sv =====
// priority_lossy_ring_buffer: top level, slot pipeline, pointers and result register
// depends on plrb_pkg, plrb_req_if, plrb_rsp_if, plrb_slot_ram
// a request transfer loads stage 1, and its result then loads the result register
// throughput: one request per cycle unless rsp.ready stalls; read-modify-write of the
//   slot ram is one stage deep, the in-flight item's write bypassed to the next read
// reset: pointers cleared, no slot holds an entry; slots not yet reached by the write
//   pointer since reset read as empty, so there is no clearing pass
`default_nettype none

module priority_lossy_ring_buffer import plrb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	plrb_req_if.sink  req,
	plrb_rsp_if.source rsp
);

	// pointers and fill tracking
	ptr_t wp_q;
	ptr_t rp_q;
	logic wrapped_q;

	// stage 1: item with its slot read
	logic               valid_s1;
	logic               kind_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [DATA_W-1:0]  payload_s1;
	ptr_t               addr_s1;
	logic               fill_s1;
	logic               byp_s1;
	entry_t             byp_data_s1;
	entry_t             rd_data_s1;

	// result register
	logic               rsp_valid_q;
	status_t            status_q;
	logic [DATA_W-1:0]  payload_q;
	logic [LEVEL_W-1:0] level_q;
	logic               skipped_q;

	logic    adv;
	logic    fire_s1;
	logic    accept;
	ptr_t    wp_d;
	ptr_t    rp_d;
	ptr_t    rd_addr;
	logic    rd_fill;
	logic    rd_byp;
	entry_t  cur;
	entry_t  nxt;
	status_t st;
	logic    pop_ok;
	logic    is_push;

	// handshake
	assign adv       = !rsp_valid_q || rsp.ready;
	assign fire_s1   = valid_s1 && adv;
	assign req.ready = !valid_s1 || adv;
	assign accept    = req.valid && req.ready;

	// effective slot contents seen by stage 1
	always_comb begin
		if (byp_s1) begin
			cur = byp_data_s1;
		end else begin
			cur = rd_data_s1;
			if (!fill_s1) begin
				cur.count = '0;
			end
		end
	end

	// slot update and result status
	always_comb begin
		nxt     = cur;
		st      = ST_POP_EMPTY;
		pop_ok  = 1'b0;
		is_push = (kind_s1 == KIND_PUSH);
		if (is_push) begin
			if ((cur.count != '0) && (cur.level > level_s1)) begin
				st = ST_PUSH_DROP;
			end else begin
				st          = ST_PUSH_OK;
				nxt.payload = payload_s1;
				nxt.level   = level_s1;
				nxt.count   = cnt_inc(cur.count);
			end
		end else if (cur.count != '0) begin
			st        = ST_POP_OK;
			pop_ok    = 1'b1;
			nxt.count = '0;
		end
	end

	// pointer values after the stage 1 item completes
	assign wp_d = (fire_s1 && is_push) ? ptr_inc(wp_q) : wp_q;
	assign rp_d = (fire_s1 && pop_ok)  ? ptr_inc(rp_q) : rp_q;

	// slot address of the incoming request, bypass and fill check
	assign rd_addr = (req.kind == KIND_POP) ? rp_d : wp_d;
	assign rd_byp  = fire_s1 && (addr_s1 == rd_addr);
	assign rd_fill = wrapped_q || (rd_addr < wp_q);

	plrb_slot_ram u_ram (
		.clk   (clk),
		.we    (fire_s1),
		.waddr (addr_s1),
		.wdata (nxt),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data_s1)
	);

	// pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			wrapped_q <= 1'b0;
		end else begin
			wp_q <= wp_d;
			rp_q <= rp_d;
			if (fire_s1 && is_push && (wp_q == PTR_W'(SLOTS - 1))) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= req.kind;
			level_s1    <= req.level_in;
			payload_s1  <= req.payload_in;
			addr_s1     <= rd_addr;
			fill_s1     <= rd_fill;
			byp_s1      <= rd_byp;
			byp_data_s1 <= nxt;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_q  <= st;
			payload_q <= pop_ok ? cur.payload : '0;
			level_q   <= pop_ok ? cur.level : '0;
			skipped_q <= pop_ok && (cur.count > CNT_W'(1));
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.payload_out = payload_q;
	assign rsp.level_out   = level_q;
	assign rsp.skipped     = skipped_q;

	// a stalled stage 1 item stays in place
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("stage 1 item lost under stall");

	// a completed push always moves the write pointer
	a_wp_adv: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && is_push |=> wp_q != $past(wp_q))
		else $error("write pointer did not advance on push");

	// the read pointer moves only on a delivered pop
	a_rp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire_s1 && pop_ok) |=> rp_q == $past(rp_q))
		else $error("read pointer moved without delivery");

	// only a delivered pop carries data
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_q != ST_POP_OK) |-> (payload_q == '0) && (level_q == '0)
			&& !skipped_q)
		else $error("nonzero fields on a result without delivery");

endmodule

`default_nettype wire
